### rtl/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types and constants of the setpoint ramp generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned STEP_W = 21;
  localparam int unsigned AXES = 4;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [31:0] goal_yaw;
    logic               jump;
  } srg_in_t;

  typedef struct packed {
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
    logic signed [31:0] ref_yaw;
  } srg_out_t;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_GOAL = 1'b1;

endpackage

### rtl/setpoint_ramp_generator_unit.sv
// ----------------------------------------------------------------------------
// setpoint_ramp_generator_unit
// Linear setpoint ramp: loads goals, steps a reference toward them per tick.
// ----------------------------------------------------------------------------
//  channel | signals                    | dir
//  --------+----------------------------+-----
//  input   | in_valid, in_ready, in_data| in
//  output  | out_valid, out_ready, out  | out
//  config  | cfg_valid, cfg_ready, cfg  | in
//
// A goal request is only stored and shows no result. A plain tick ramps one
// axis a cycle and then shows its result. The first ramp tick after a goal
// first finds the magnitudes, the sum of squares, a square root and a division
// per axis; zero distance snaps to the goal, as does a tick after a jump goal.
// Reset is synchronous and clears state and step_length to its default.
// A result waiting at the output holds off the next request.
module setpoint_ramp_generator_unit #(
  parameter int unsigned FRAC_BITS = srg_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  srg_pkg::srg_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output srg_pkg::srg_out_t              out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srg_pkg::STEP_W-1:0]     cfg
);
  import srg_pkg::*;

  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'((3 << FRAC_BITS) / 100);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_ADV   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]               state;
  logic [STEP_W-1:0]        step_length;
  logic signed [31:0]       goal  [AXES];
  logic signed [31:0]       refv  [AXES];
  logic signed [31:0]       step  [AXES];
  logic                     goal_pending, jump_pending;
  logic [1:0]               ax;
  logic [6:0]               cnt;
  logic [32:0]              dmag  [3];
  logic                     sh;
  logic [65:0]              sum;
  // square root working registers
  logic [65:0]              rem;
  logic [33:0]              root;
  logic [32:0]              xyz_len;
  // division working registers
  logic [53:0]              num;
  logic [53:0]              quo;
  logic [33:0]              drem;

  // per-axis difference, 33 bits
  logic signed [32:0]       d_cur;
  logic [32:0]              m_cur;
  logic [34:0]              div_try;
  logic signed [33:0]       sum_ref;

  assign d_cur = 33'(goal[ax]) - 33'(refv[ax]);
  assign m_cur = d_cur[32] ? 33'(-d_cur) : 33'(d_cur);
  assign sum_ref = 34'(refv[ax]) + 34'(step[ax]);

  // root: two bits of the radicand per cycle
  logic [35:0] rtrial;
  logic [35:0] rnew;
  assign rnew   = {rem[33:0], sum[65:64]};
  assign rtrial = rnew - {root, 2'b01};

  // division: one quotient bit per cycle
  logic [34:0] dshift;
  assign dshift  = {drem, num[53]};
  assign div_try = dshift - {2'b0, xyz_len};

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) step_length <= STEP_RST;
    else if (cfg_valid && cfg_ready) step_length <= cfg;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      goal_pending <= 1'b0;
      jump_pending <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        goal[i] <= '0;
        refv[i] <= '0;
        step[i] <= '0;
      end
      ax <= '0;
      cnt <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            ax <= '0;
            if (in_data.mode == MODE_GOAL) begin
              goal[0] <= in_data.goal_x;
              goal[1] <= in_data.goal_y;
              goal[2] <= in_data.goal_z;
              goal[3] <= in_data.goal_yaw;
              jump_pending <= in_data.jump;
              goal_pending <= 1'b1;
            end else if (goal_pending && jump_pending) begin
              for (int i = 0; i < AXES; i++) refv[i] <= goal[i];
              goal_pending <= 1'b0;
              state <= S_OUT;
            end else if (goal_pending) begin
              goal_pending <= 1'b0;
              state <= S_DIFF;
            end else begin
              state <= S_ADV;
            end
          end
        end
        // latch xyz magnitudes, one axis a cycle
        S_DIFF: begin
          dmag[ax] <= m_cur;
          if (ax == 2'd2) begin
            ax <= '0;
            sh <= dmag[0][31] | dmag[0][32] | dmag[1][31] | dmag[1][32] |
                  m_cur[31] | m_cur[32];
            sum <= '0;
            state <= S_SQ;
          end else ax <= ax + 2'd1;
        end
        // sum of squares, one 32x32 product a cycle
        S_SQ: begin
          logic [31:0] t;
          t = sh ? dmag[ax][32:1] : dmag[ax][31:0];
          sum <= sum + 66'(64'(t) * 64'(t));
          if (ax == 2'd2) begin
            ax <= '0;
            rem <= '0;
            root <= '0;
            cnt <= 7'd33;
            state <= S_SQRT;
          end else ax <= ax + 2'd1;
        end
        S_SQRT: begin
          if (!rtrial[35]) begin
            rem  <= 66'(rtrial);
            root <= {root[32:0], 1'b1};
          end else begin
            rem  <= 66'(rnew);
            root <= {root[32:0], 1'b0};
          end
          sum <= {sum[63:0], 2'b00};
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) state <= S_MUL;
        end
        // distance, then zero check; prepare numerator for axis ax
        S_MUL: begin
          logic [32:0] dv;
          dv = sh ? {root[31:0], 1'b0} : {1'b0, root[31:0]};
          xyz_len <= dv;
          if (dv == '0) begin
            for (int i = 0; i < AXES; i++) begin
              step[i] <= '0;
              refv[i] <= goal[i];
            end
            state <= S_OUT;
          end else begin
            num  <= 54'(m_cur) * 54'(step_length);
            drem <= '0;
            quo  <= '0;
            cnt  <= 7'd54;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          logic [53:0] qn;
          if (!div_try[34]) begin
            drem <= div_try[33:0];
            qn = {quo[52:0], 1'b1};
          end else begin
            drem <= dshift[33:0];
            qn = {quo[52:0], 1'b0};
          end
          quo <= qn;
          num <= {num[52:0], 1'b0};
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            logic [31:0] q;
            q = (qn > 54'h7FFF_FFFF) ? 32'h7FFF_FFFF : qn[31:0];
            if (q == '0 && m_cur != '0) q = 32'd1;
            step[ax] <= d_cur[32] ? -q : q;
            if (ax == 2'd3) begin
              ax <= '0;
              state <= S_ADV;
            end else begin
              ax <= ax + 2'd1;
              state <= S_MUL;
            end
          end
        end
        // ramp or snap, one axis a cycle
        S_ADV: begin
          logic [33:0] smag;
          smag = step[ax][31] ? 34'(-35'(step[ax])) : 34'(step[ax]);
          if (34'(m_cur) > {smag[32:0], 1'b0}) begin
            if (sum_ref > 34'sh0_7FFF_FFFF) refv[ax] <= 32'sh7FFF_FFFF;
            else if (sum_ref < -34'sh0_8000_0000) refv[ax] <= 32'sh8000_0000;
            else refv[ax] <= sum_ref[31:0];
          end else refv[ax] <= goal[ax];
          if (ax == 2'd3) begin
            ax <= '0;
            state <= S_OUT;
          end else ax <= ax + 2'd1;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out.ref_x   = refv[0];
  assign out.ref_y   = refv[1];
  assign out.ref_z   = refv[2];
  assign out.ref_yaw = refv[3];

  // checks
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_IDLE) else $error("result shown while busy");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_valid) else $error("result lost");

endmodule

### verif/setpoint_ramp_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// setpoint_ramp_generator_unit_tb
// Drives goal and tick requests through the ramp generator at several idling
// mixes and step_length settings, and checks every emitted reference against
// a bit-accurate predictor held in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module setpoint_ramp_generator_unit_tb;
  import srg_pkg::*;

  localparam int unsigned N_AX = 4;
  localparam logic [STEP_W-1:0] STEP_LEN_RESET = 21'd1966;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;

  // ramp predictor and store of expected references
  class ramp_scoreboard;
    longint goal_pos[N_AX];
    longint ref_pos[N_AX];
    longint step_val[N_AX];
    bit goal_new;
    bit jump_new;
    longint unsigned step_len;
    srg_out_t expected_refs[$];
    int mismatches;

    function void clear_state();
      for (int i = 0; i < N_AX; i++) begin
        goal_pos[i] = 0;
        ref_pos[i] = 0;
        step_val[i] = 0;
      end
      goal_new = 0;
      jump_new = 0;
      step_len = STEP_LEN_RESET;
      expected_refs.delete();
      mismatches = 0;
    endfunction

    function longint unsigned abs_val(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void plan_steps();
      longint d[N_AX];
      longint unsigned big;
      longint unsigned sum;
      longint unsigned span;
      longint unsigned q;
      longint unsigned t;
      int sh;
      big = 0;
      sum = 0;
      sh = 0;
      for (int i = 0; i < N_AX; i++) d[i] = goal_pos[i] - ref_pos[i];
      for (int i = 0; i < 3; i++) if (abs_val(d[i]) > big) big = abs_val(d[i]);
      if (big >= (64'd1 << 31)) sh = 1;
      for (int i = 0; i < 3; i++) begin
        t = abs_val(d[i]) >> sh;
        sum += t * t;
      end
      span = int_sqrt(sum) << sh;
      // goal at zero xyz distance snaps at once, yaw included
      if (span == 0) begin
        for (int i = 0; i < N_AX; i++) begin
          step_val[i] = 0;
          ref_pos[i] = goal_pos[i];
        end
        return;
      end
      for (int i = 0; i < N_AX; i++) begin
        q = (abs_val(d[i]) * step_len) / span;
        if (q > SAT_MAX) q = SAT_MAX;
        if (q == 0 && d[i] != 0) q = 1;
        step_val[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
      end
    endfunction

    // note one accepted request
    function void note_request(srg_in_t r);
      srg_out_t o;
      longint d;
      longint s;
      if (r.mode == MODE_GOAL) begin
        goal_pos[0] = r.goal_x;
        goal_pos[1] = r.goal_y;
        goal_pos[2] = r.goal_z;
        goal_pos[3] = r.goal_yaw;
        jump_new = r.jump;
        goal_new = 1;
        return;
      end
      if (goal_new && jump_new) begin
        for (int i = 0; i < N_AX; i++) ref_pos[i] = goal_pos[i];
        goal_new = 0;
      end else begin
        if (goal_new) begin
          plan_steps();
          goal_new = 0;
        end
        for (int i = 0; i < N_AX; i++) begin
          d = goal_pos[i] - ref_pos[i];
          if (abs_val(d) > 2 * abs_val(step_val[i])) begin
            s = ref_pos[i] + step_val[i];
            ref_pos[i] = (s > SAT_MAX) ? SAT_MAX : (s < SAT_MIN) ? SAT_MIN : s;
          end else begin
            ref_pos[i] = goal_pos[i];
          end
        end
      end
      o.ref_x = ref_pos[0][31:0];
      o.ref_y = ref_pos[1][31:0];
      o.ref_z = ref_pos[2][31:0];
      o.ref_yaw = ref_pos[3][31:0];
      expected_refs = {expected_refs, o};
    endfunction

    // check one emitted reference
    function void check_ref(srg_out_t got);
      srg_out_t e;
      if (expected_refs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reference %h", got);
        return;
      end
      e = expected_refs.pop_front();
      if (got.ref_x !== e.ref_x || got.ref_y !== e.ref_y ||
          got.ref_z !== e.ref_z || got.ref_yaw !== e.ref_yaw) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ref mismatch exp x=%h y=%h z=%h yaw=%h got x=%h y=%h z=%h yaw=%h",
                   e.ref_x, e.ref_y, e.ref_z, e.ref_yaw,
                   got.ref_x, got.ref_y, got.ref_z, got.ref_yaw);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  srg_in_t in_data;
  logic out_valid;
  logic out_ready;
  srg_out_t out;
  logic cfg_valid;
  logic cfg_ready;
  logic [STEP_W-1:0] cfg;

  ramp_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int hold_count;

  setpoint_ramp_generator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out(out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      hold_count <= 0;
    end else begin
      if (out_valid && out_ready) sb.check_ref(out);
      if (hold_count < hold_cycles) begin
        hold_count <= hold_count + 1;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      3: return $urandom_range(0, 8) - 4;
      default: return {{14{1'($urandom_range(1))}}, 18'($urandom)};
    endcase
  endfunction

  // one request, held until accepted
  task automatic send_req(input srg_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic send_goal(input logic [31:0] x, y, z, yaw, input logic j);
    srg_in_t r;
    r.mode = MODE_GOAL;
    r.goal_x = x;
    r.goal_y = y;
    r.goal_z = z;
    r.goal_yaw = yaw;
    r.jump = j;
    send_req(r);
  endtask

  task automatic send_tick();
    srg_in_t r;
    r = srg_in_t'(130'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    r.mode = MODE_TICK;
    send_req(r);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_refs.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_step_len(input logic [STEP_W-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.step_len = v;
    cfg_valid <= 0;
  endtask

  // goal, sometimes a second goal, followed by a run of ticks
  task automatic random_burst(inout int budget);
    int n;
    send_goal(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              ($urandom_range(7) == 0));
    budget--;
    if ($urandom_range(9) == 0) begin
      send_goal(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                1'($urandom_range(1)));
      budget--;
    end
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      send_tick();
      budget--;
    end
  endtask

  initial begin
    int budget;
    logic [STEP_W-1:0] lens[5];
    sb = new();
    sb.clear_state();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, extremes and special cases
    send_tick();
    send_goal(32'h00010000, 32'h00020000, 32'h0, 32'h00008000, 1'b0);
    repeat (4) send_tick();
    send_goal(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
    repeat (3) send_tick();
    send_goal(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
    send_tick();
    send_goal(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h00001234, 1'b0);
    send_tick();
    send_goal(32'h0, 32'h0, 32'h0, 32'h00001234, 1'b1);
    send_goal(32'h5, 32'h0, 32'h0, 32'hfffffff0, 1'b0);
    repeat (3) send_tick();
    send_goal(32'h7fffffff, 32'h0, 32'h0, 32'h0, 1'b0);
    send_tick();
    write_step_len(21'h100000);
    send_goal(32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff, 1'b0);
    repeat (2) send_tick();
    write_step_len(21'd1);
    send_goal(32'h00400000, 32'h0, 32'h0, 32'h0, 1'b0);
    repeat (2) send_tick();

    // random phases over several settings and idling mixes
    lens = '{21'd1, 21'h1fffff, 21'd1966, 21'h100000, 21'h0};
    budget = 1850;
    for (int ph = 0; ph < 8 && budget > 0; ph++) begin
      write_step_len((ph == 7) ? 21'($urandom) : lens[ph % 5]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (ph == 1) begin
        send_idle_pct = 0;
        hold_cycles = 3000;
      end
      for (int k = 0; k < 60 && budget > 0; k++) begin
        random_burst(budget);
        if (ph == 1 && k == 10) send_idle_pct = 85;
      end
      // sender pauses until all references are back
      if (ph == 3) drain();
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_refs.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

### files.f
rtl/srg_pkg.sv
rtl/setpoint_ramp_generator_unit.sv
verif/setpoint_ramp_generator_unit_tb.sv
